// File: rtl/core/jset_pkg.sv
// Package for the Julia-set escape-time block: widths, reset values,
// register indexes, controller state encoding and command/status types.
// No dependencies.
`timescale 1ns / 1ps

package jset_pkg;

   localparam int FRAC_BITS      = 26;
   localparam int COORD_W        = 32;
   localparam int STEP_W         = 31;
   localparam int IDX_W          = 13;
   localparam int Z_W            = 34;
   localparam int MUL_W          = 29;
   localparam int PROD_W         = 2 * MUL_W;
   localparam int COUNT_W        = 8;
   localparam int CSR_IDX_W      = 3;
   localparam int REQ_DATA_W     = 32;
   localparam int MAX_PASSES_DEF = 256;

   localparam logic signed [COORD_W-1:0] C_REAL_RST     = -32'sd26843546;
   localparam logic signed [COORD_W-1:0] C_IMAG_RST     = 32'sd40265318;
   localparam logic signed [COORD_W-1:0] START_REAL_RST = -32'sd167728470;
   localparam logic signed [COORD_W-1:0] START_IMAG_RST = -32'sd167694488;
   localparam logic [STEP_W-1:0]         STEP_REAL_RST  = 31'd87381;
   localparam logic [STEP_W-1:0]         STEP_IMAG_RST  = 31'd155345;

   // |z| component bound (2.0) and escape bound on |z|^2 (4.0 in Q7.52)
   localparam logic signed [Z_W-1:0] MAG_POS = 34'sd134217728;
   localparam logic signed [Z_W-1:0] MAG_NEG = -34'sd134217728;
   localparam logic [PROD_W:0]       ESC_LIMIT = (PROD_W+1)'(1) << (2 * FRAC_BITS + 2);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_C_REAL     = 3'd0,
      REG_C_IMAG     = 3'd1,
      REG_START_REAL = 3'd2,
      REG_START_IMAG = 3'd3,
      REG_STEP_REAL  = 3'd4,
      REG_STEP_IMAG  = 3'd5
   } csr_idx_type;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_INIT = 5'b00010,
      S_MULT = 5'b00100,
      S_UPD  = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   typedef struct packed {
      logic load;
      logic init;
      logic mult;
      logic update;
      logic capture;
   } cmd_type;

   typedef struct packed {
      logic max_reached;
      logic escaped;
   } status_type;

endpackage

// File: rtl/core/jset_datapath.sv
// Datapath: configuration registers, start-point mapping, squaring and cross-product
// multipliers, z update, pass counter and result register. Uses jset_pkg.
`timescale 1ns / 1ps

module jset_datapath import jset_pkg::*; #(
   parameter int MAX_PASSES = MAX_PASSES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [COORD_W-1:0]    csr_wdata,
   input  logic [IDX_W-1:0]      row,
   input  logic [IDX_W-1:0]      col,
   input  cmd_type               cmd,
   output status_type            status,
   output logic [COUNT_W-1:0]    escape_count
);

   localparam int CNT_W = $clog2(MAX_PASSES + 1);
   localparam int OFS_W = IDX_W + STEP_W;
   localparam int SUM_W = OFS_W + 2;

   logic signed [COORD_W-1:0] c_real_ff, c_imag_ff, start_real_ff, start_imag_ff;
   logic [STEP_W-1:0]         step_real_ff, step_imag_ff;
   logic [OFS_W-1:0]          ofs_re_ff, ofs_im_ff;
   logic signed [Z_W-1:0]     z_re_ff, z_re_in, z_im_ff, z_im_in;
   logic signed [PROD_W-1:0]  rr_ff, ii_ff, ri_ff;
   logic                      big_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic [COUNT_W-1:0]        result_ff;

   logic signed [SUM_W-1:0]   sum_re, sum_im;
   logic signed [MUL_W-1:0]   re_m, im_m;
   logic [PROD_W:0]           mag_sq;
   logic signed [PROD_W:0]    diff;
   logic signed [PROD_W:0]    diff_sh;
   logic signed [PROD_W-1:0]  ri_sh;

   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'($signed({1'b0, {(COORD_W-1){1'b1}}}));
      lo = -hi - SUM_W'(1);
      if (v > hi) begin
         sat_coord = hi[COORD_W-1:0];
      end else if (v < lo) begin
         sat_coord = lo[COORD_W-1:0];
      end else begin
         sat_coord = v[COORD_W-1:0];
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         c_real_ff     <= C_REAL_RST;
         c_imag_ff     <= C_IMAG_RST;
         start_real_ff <= START_REAL_RST;
         start_imag_ff <= START_IMAG_RST;
         step_real_ff  <= STEP_REAL_RST;
         step_imag_ff  <= STEP_IMAG_RST;
      end else if (csr_wen) begin
         case (csr_index)
            REG_C_REAL:     c_real_ff     <= csr_wdata;
            REG_C_IMAG:     c_imag_ff     <= csr_wdata;
            REG_START_REAL: start_real_ff <= csr_wdata;
            REG_START_IMAG: start_imag_ff <= csr_wdata;
            REG_STEP_REAL:  step_real_ff  <= csr_wdata[STEP_W-1:0];
            REG_STEP_IMAG:  step_imag_ff  <= csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   assign sum_re = SUM_W'(start_real_ff) + $signed({2'b00, ofs_re_ff});
   assign sum_im = SUM_W'(start_imag_ff) + $signed({2'b00, ofs_im_ff});

   assign re_m = z_re_ff[MUL_W-1:0];
   assign im_m = z_im_ff[MUL_W-1:0];

   // squares are non-negative, so the top bit is a plain zero extension
   assign mag_sq  = {1'b0, rr_ff} + {1'b0, ii_ff};
   assign diff    = (PROD_W+1)'(rr_ff) - (PROD_W+1)'(ii_ff);
   assign diff_sh = diff >>> FRAC_BITS;
   assign ri_sh   = ri_ff >>> (FRAC_BITS - 1);

   always_comb begin
      z_re_in = z_re_ff;
      z_im_in = z_im_ff;
      if (cmd.init) begin
         z_re_in = Z_W'(sat_coord(sum_re));
         z_im_in = Z_W'(sat_coord(sum_im));
      end else if (cmd.update) begin
         z_re_in = diff_sh[Z_W-1:0] + Z_W'(c_real_ff);
         z_im_in = ri_sh[Z_W-1:0] + Z_W'(c_imag_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ofs_re_ff <= OFS_W'(col) * OFS_W'(step_real_ff);
         ofs_im_ff <= OFS_W'(row) * OFS_W'(step_imag_ff);
      end
      z_re_ff <= z_re_in;
      z_im_ff <= z_im_in;
      if (cmd.mult) begin
         big_ff <= (z_re_ff > MAG_POS) || (z_re_ff < MAG_NEG) ||
                   (z_im_ff > MAG_POS) || (z_im_ff < MAG_NEG);
         rr_ff  <= re_m * re_m;
         ii_ff  <= im_m * im_m;
         ri_ff  <= re_m * im_m;
      end
      if (cmd.capture) begin
         result_ff <= COUNT_W'(cnt_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.init) begin
         cnt_ff <= '0;
      end else if (cmd.update) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   assign status.max_reached = (cnt_ff == CNT_W'(MAX_PASSES));
   assign status.escaped     = big_ff || (mag_sq > ESC_LIMIT);
   assign escape_count       = result_ff;

endmodule

// File: rtl/core/jset_ctrl.sv
// Controller: one-hot state machine sequencing load, init, multiply and
// update passes, and the result handshake. Uses jset_pkg.
`timescale 1ns / 1ps

module jset_ctrl import jset_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  status_type  status,
   output cmd_type     cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            cmd.init = 1'b1;
            state_in = S_MULT;
         end
         S_MULT: begin
            if (status.max_reached) begin
               state_in = S_DONE;
            end else begin
               cmd.mult = 1'b1;
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            if (status.escaped) begin
               state_in = S_DONE;
            end else begin
               cmd.update = 1'b1;
               state_in   = S_MULT;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.capture  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/core/julia_set_escape_time_top.sv
// Top level of the Julia-set escape-time block: joins controller and datapath.
// Depends on jset_pkg, jset_ctrl and jset_datapath.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_tvalid/tready   | tdata: row[12:0], col[25:13]
//  rsp     | out       | rsp_tvalid/tready   | tdata: escape_count[7:0]
//  csr     | in        | csr_wen             | csr_index, csr_wdata
//
// An item passes through the load and init states, then alternates between the multiply
// and update states around the squaring multipliers until it escapes or its pass count
// reaches MAX_PASSES.
// One item at a time; the next is taken while the previous result waits in rsp.
// Synchronous active-high reset restores the register defaults.
// A stalled rsp holds the finished item; the block waits only if a second one completes.
`timescale 1ns / 1ps

module julia_set_escape_time_top import jset_pkg::*; #(
   parameter int MAX_PASSES = MAX_PASSES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // row[12:0], col[25:13]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [COUNT_W-1:0]    rsp_tdata,   // escape_count[7:0]
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [COORD_W-1:0]    csr_wdata
);

   cmd_type    cmd;
   status_type status;

   jset_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   jset_datapath #(
      .MAX_PASSES (MAX_PASSES)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_wen      (csr_wen),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .row          (req_tdata[IDX_W-1:0]),
      .col          (req_tdata[2*IDX_W-1:IDX_W]),
      .cmd          (cmd),
      .status       (status),
      .escape_count (rsp_tdata)
   );

endmodule
